FILE: src/b64e_pkg.sv
// Shared types and constants for the URL-safe base64 encoder.
// No dependencies; used by every module of the encoder.
package b64e_pkg;

  localparam logic [7:0] PadChar = 8'h3D;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_e;

  // one encoded request: two sextets, character count minus one, end of text
  typedef struct packed {
    logic [5:0] sx0;
    logic [5:0] sx1;
    logic [1:0] cnt_m1;
    logic       eot;
  } job_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    c = {2'b00, v};
    if (v < 6'd26) begin
      sextet_char = 8'h41 + c;
    end else if (v < 6'd52) begin
      sextet_char = 8'h61 + c - 8'd26;
    end else if (v < 6'd62) begin
      sextet_char = 8'h30 + c - 8'd52;
    end else if (v == 6'd62) begin
      sextet_char = 8'h2D;
    end else begin
      sextet_char = 8'h5F;
    end
  endfunction

endpackage

FILE: src/b64e_front.sv
// Front end: accepts source bytes, tracks group phase and carry bits,
// and builds one job per byte. Depends on b64e_pkg.
module b64e_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     data_byte_i,
  input  logic           end_of_data_i,
  output b64e_pkg::job_t job_o
);

  b64e_pkg::phase_e phase_q, phase_d;
  logic [3:0]       carry_q, carry_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= b64e_pkg::PH_FIRST;
      carry_q <= 4'd0;
    end else begin
      phase_q <= phase_d;
      carry_q <= carry_d;
    end
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    carry_d = carry_q;
    if (accept_i) begin
      if (end_of_data_i) begin
        phase_d = b64e_pkg::PH_FIRST;
        carry_d = 4'd0;
      end else begin
        case (phase_q)
          b64e_pkg::PH_SECOND: begin
            phase_d = b64e_pkg::PH_THIRD;
            carry_d = data_byte_i[3:0];
          end
          b64e_pkg::PH_THIRD: begin
            phase_d = b64e_pkg::PH_FIRST;
            carry_d = 4'd0;
          end
          default: begin
            phase_d = b64e_pkg::PH_SECOND;
            carry_d = {2'b00, data_byte_i[1:0]};
          end
        endcase
      end
    end
  end

  // job contents
  always_comb begin
    job_o.eot = end_of_data_i;
    case (phase_q)
      b64e_pkg::PH_SECOND: begin
        job_o.sx0    = {carry_q[1:0], data_byte_i[7:4]};
        job_o.sx1    = {data_byte_i[3:0], 2'b00};
        job_o.cnt_m1 = end_of_data_i ? 2'd2 : 2'd0;
      end
      b64e_pkg::PH_THIRD: begin
        job_o.sx0    = {carry_q, data_byte_i[7:6]};
        job_o.sx1    = data_byte_i[5:0];
        job_o.cnt_m1 = 2'd1;
      end
      default: begin
        job_o.sx0    = data_byte_i[7:2];
        job_o.sx1    = {data_byte_i[1:0], 4'b0000};
        job_o.cnt_m1 = end_of_data_i ? 2'd3 : 2'd0;
      end
    endcase
  end

endmodule

FILE: src/b64e_fifo.sv
// Short job queue between front and back end.
// Depends on b64e_pkg for the job type.
module b64e_fifo #(
  parameter int Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b64e_pkg::job_t push_data_i,
  input  logic           pop_i,
  output b64e_pkg::job_t head_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  b64e_pkg::job_t  slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == DepthCnt);
  assign empty_o = (count_q == '0);
  assign head_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: src/b64e_back.sv
// Back end: walks the head job one character per cycle into the output register while not stalled.
// Depends on b64e_pkg for the job type and the alphabet function.
module b64e_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  b64e_pkg::job_t head_i,
  input  logic           head_valid_i,
  output logic           pop_o,
  output logic           m_axis_tvalid_o,
  input  logic           m_axis_tready_i,
  output logic [7:0]     m_axis_tdata_o,
  output logic           m_axis_tlast_o,
  output logic           m_axis_tuser_o
);

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] char_q, char_d;
  logic       last_q, user_q;
  logic       load, emit, at_end;

  assign load   = !valid_q || m_axis_tready_i;
  assign emit   = load && head_valid_i;
  assign at_end = (idx_q == head_i.cnt_m1);
  assign pop_o  = emit && at_end;

  always_comb begin
    case (idx_q)
      2'd0:    char_d = b64e_pkg::sextet_char(head_i.sx0);
      2'd1:    char_d = b64e_pkg::sextet_char(head_i.sx1);
      default: char_d = b64e_pkg::PadChar;
    endcase
  end

  always_comb begin
    idx_d   = idx_q;
    valid_d = load ? head_valid_i : valid_q;
    if (emit) begin
      idx_d = at_end ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      char_q <= char_d;
      user_q <= at_end;
      last_q <= at_end && head_i.eot;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = char_q;
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tuser_o  = user_q;

  a_eot_is_item_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o)
    else $error("end of text without end of request");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> idx_q <= head_i.cnt_m1)
    else $error("character index past job length");

  a_idle_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_i |-> idx_q == 2'd0)
    else $error("character index left over with no job");

  a_pop_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> idx_q == 2'd0)
    else $error("index not reset after job done");

endmodule

FILE: src/base64url_encoder_unit.sv
// Top level of the streaming URL-safe base64 encoder with '=' padding.
// Depends on b64e_pkg, b64e_front, b64e_fifo and b64e_back.
//
// Takes one source byte per request (tlast marks the final byte) and gives one
// character per request on the master side from the alphabet A-Z a-z 0-9 - _,
// with '=' padding after the final byte. Output tuser marks the last character
// a byte produces; output tlast marks the end of the text. The output register
// delivers one character per cycle unless held by back-pressure; a byte yields
// 1, 2, 3 or 4 characters (1 in phases 0 and 1, 2 in phase 2, 2 to 4 for the
// final byte); bytes are taken every cycle while the FifoDepth-entry job queue has room.
module base64url_encoder_unit #(
  parameter int FifoDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,   // end_of_data
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] text_char
  output logic       m_axis_tlast_o,   // end_of_text
  output logic       m_axis_tuser_o    // [0] last_of_item
);

  b64e_pkg::job_t job, head;
  logic           full, empty, accept, pop;

  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && !full;

  b64e_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (s_axis_tdata_i),
    .end_of_data_i (s_axis_tlast_i),
    .job_o         (job)
  );

  b64e_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (job),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (full),
    .empty_o     (empty)
  );

  b64e_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .head_valid_i    (!empty),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule
